/* src/adf_pkg.sv */
// ----------------------------------------------------------------------------
// adf_pkg
// shared constants, register codes and controller/datapath handshake types
// for the allpass delay filter
// ----------------------------------------------------------------------------
`default_nettype none

package adf_pkg;

	localparam int ADF_MAX_DELAY = 2048;
	localparam int SAMPLE_W      = 32;
	localparam int LEN_W         = 12;
	localparam int PROD_W        = 64;
	localparam int GAIN_SHIFT    = 25;
	localparam logic [PROD_W-1:0] ROUND_BIAS = 64'h0000_0000_0100_0000;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 12'd2048;

	// register index on the config port
	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	// request codes on the cmd field
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load_x;    // capture input sample, read delay word at index
		logic mul_en;    // register delayed word times gain
		logic commit;    // write back, step index, load output register
		logic clr_start; // arm clear sweep over the active length
		logic clr_step;  // zero one entry of the sweep
	} adf_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;  // sweep counter reached its limit
		logic out_busy;  // output register holds an untaken result
	} adf_sts_t;

endpackage

`default_nettype wire

/* src/adf_ram.sv */
// ----------------------------------------------------------------------------
// adf_ram
// generic single-port ram, write or registered read each cycle
// ----------------------------------------------------------------------------
`default_nettype none

module adf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/adf_ctrl.sv */
// ----------------------------------------------------------------------------
// adf_ctrl
// sequencer for one request at a time: read, multiply, write back, or clear
// ----------------------------------------------------------------------------
`default_nettype none

module adf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              cmd,
	input  wire adf_pkg::adf_sts_t sts,
	output adf_pkg::adf_ctl_t      ctl
);

	import adf_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MUL   = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;
	localparam logic [1:0] S_CLEAR = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == CMD_CLEAR) begin
						ctl.clr_start = 1'b1;
						state_d       = S_CLEAR;
					end else begin
						ctl.load_x = 1'b1;
						state_d    = S_MUL;
					end
				end
			end
			S_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = S_WRITE;
			end
			S_WRITE: begin
				if (!sts.out_busy) begin
					ctl.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end else begin
					ctl.clr_step = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// reset lands in the clear sweep so the store starts zeroed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* src/adf_dp.sv */
// ----------------------------------------------------------------------------
// adf_dp
// delay line, index, feedback multiply, clear counter and output register
// ----------------------------------------------------------------------------
`default_nettype none

module adf_dp #(
	parameter int MAX_DELAY = adf_pkg::ADF_MAX_DELAY
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire adf_pkg::adf_ctl_t             ctl,
	output adf_pkg::adf_sts_t                  sts,
	input  wire logic [adf_pkg::SAMPLE_W-1:0]  sample_in,
	input  wire logic [adf_pkg::SAMPLE_W-1:0]  feedback_gain,
	input  wire logic [adf_pkg::LEN_W-1:0]     delay_length,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [adf_pkg::SAMPLE_W-1:0]  sample_out
);

	import adf_pkg::*;

	localparam int AW = $clog2(MAX_DELAY);
	localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DELAY);

	logic [AW-1:0]       pos_q;
	logic [CW-1:0]       clr_q;
	logic [CW-1:0]       lim_q;
	logic [SAMPLE_W-1:0] x_q;
	logic [SAMPLE_W-1:0] d_q;
	logic [PROD_W-1:0]   prod_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_q;

	logic [CW-1:0]       len_ext;
	logic [CW-1:0]       act_len;
	logic [CW-1:0]       pos_inc;
	logic [PROD_W-1:0]   prod_rnd;
	logic [SAMPLE_W-1:0] fb_term;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [SAMPLE_W-1:0] ram_rdata;

	// active length saturates at the store depth
	assign len_ext = CW'(delay_length);
	assign act_len = (len_ext > MAX_C) ? MAX_C : len_ext;
	assign pos_inc = CW'(pos_q) + CW'(1);

	assign prod_rnd = prod_q + ROUND_BIAS;
	assign fb_term  = prod_rnd[GAIN_SHIFT +: SAMPLE_W];

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pos_q;
		ram_wdata = x_q + fb_term;
		if (ctl.clr_step) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q[AW-1:0];
			ram_wdata = '0;
		end else if (ctl.commit) begin
			ram_we = 1'b1;
		end
	end

	adf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_DELAY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			clr_q       <= '0;
			lim_q       <= MAX_C;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clr_start) begin
				clr_q <= '0;
				lim_q <= act_len;
			end else if (ctl.clr_step) begin
				clr_q <= clr_q + CW'(1);
			end
			if (ctl.commit) begin
				pos_q       <= (pos_inc >= act_len) ? '0 : pos_inc[AW-1:0];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_x) begin
			x_q <= sample_in;
		end
		if (ctl.mul_en) begin
			d_q    <= ram_rdata;
			prod_q <= PROD_W'($signed(ram_rdata) * $signed(feedback_gain));
		end
		if (ctl.commit) begin
			out_q <= d_q - x_q;
		end
	end

	assign sts.clr_done = (clr_q >= lim_q);
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign sample_out   = out_q;

endmodule

`default_nettype wire

/* src/allpass_delay_filter_unit.sv */
// ----------------------------------------------------------------------------
// allpass_delay_filter_unit
// fixed-point allpass section over a circular delay line, with apb config
// ----------------------------------------------------------------------------
//
//  channel | signals                          | moves
//  --------+----------------------------------+------------------------------
//  in      | in_valid, in_ready, cmd,         | one request: sample or clear
//          | sample_in                        |
//  out     | out_valid, out_ready, sample_out | one result per sample request
//  apb     | psel, penable, pwrite, paddr,    | feedback_gain at 0x0,
//          | pwdata, prdata, pready           | delay_length at 0x4
//
//  a sample request steps through accept with delay line read, multiply
//  and write back; the next request is taken in idle once write back is
//  done, and the result is registered in the output register at write back
//  a clear request zeroes one entry a cycle, in_ready low until the sweep ends
//  after reset a sweep over all MAX_DELAY entries runs first with in_ready
//  low; config writes are taken throughout
//  the output register holds a result while out_ready is low; a following
//  sample request is accepted and waits at its write back until the slot frees
//
`default_nettype none

module allpass_delay_filter_unit #(
	parameter int MAX_DELAY = adf_pkg::ADF_MAX_DELAY
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         cmd,
	input  wire logic [adf_pkg::SAMPLE_W-1:0] sample_in,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [adf_pkg::SAMPLE_W-1:0] sample_out,
	// config port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	import adf_pkg::*;

	// config registers
	logic [SAMPLE_W-1:0] gain_q;
	logic [LEN_W-1:0]    len_q;
	logic                reg_sel;
	logic                cfg_wr;

	adf_ctl_t ctl;
	adf_sts_t sts;

	// word index from the byte address; low two bits ignored
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
			len_q  <= LEN_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_GAIN: gain_q <= pwdata;
				REG_LEN:  len_q  <= pwdata[LEN_W-1:0];
				default:  gain_q <= gain_q;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			REG_GAIN: prdata = gain_q;
			REG_LEN:  prdata = {{(32 - LEN_W){1'b0}}, len_q};
			default:  prdata = '0;
		endcase
	end

	// sequencer: one request at a time
	adf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.sts     (sts),
		.ctl     (ctl)
	);

	// delay line, feedback multiply, index and output register
	adf_dp #(
		.MAX_DELAY(MAX_DELAY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.sample_in    (sample_in),
		.feedback_gain(gain_q),
		.delay_length (len_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out)
	);

endmodule

`default_nettype wire

/* tb/sv/tb_allpass_delay_filter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_allpass_delay_filter_unit
// self-checking bench for the fixed-point allpass section: a queue-fed driver
// offers sample and clear requests, a shadow of the delay line predicts every
// result, and a monitor compares results in order while both sides stall at
// random and the config port steps through gains and lengths between phases
// ----------------------------------------------------------------------------

module tb_allpass_delay_filter_unit;

	import adf_pkg::*;

	localparam int IDLE_LIMIT  = 20000; // cycles with no handshake before giving up
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 125;

	typedef struct {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample;
	} adf_req_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic                cmd       = CMD_SAMPLE;
	logic [SAMPLE_W-1:0] sample_in = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] sample_out;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [2:0]          paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic [31:0]         prdata;
	logic                pready;

	// shadow of the block: delay line, index and both registers
	logic [SAMPLE_W-1:0] line_mem [ADF_MAX_DELAY];
	int unsigned         line_pos;
	logic [31:0]         gain_reg;
	logic [LEN_W-1:0]    len_reg;

	adf_req_t            pending_reqs[$];  // requests not yet offered
	logic [SAMPLE_W-1:0] expected_outs[$]; // predicted results, oldest first
	int unsigned         reqs_queued = 0;
	int unsigned         reqs_taken  = 0;
	int unsigned         err_count   = 0;

	allpass_delay_filter_unit #(
		.MAX_DELAY(ADF_MAX_DELAY)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	// lengths above the store size saturate
	function automatic int unsigned active_len();
		return (len_reg > ADF_MAX_DELAY) ? ADF_MAX_DELAY : len_reg;
	endfunction

	// one request through the shadow delay line
	function void allpass_step(input logic c, input logic [SAMPLE_W-1:0] x,
			output bit has_out, output logic [SAMPLE_W-1:0] y);
		int unsigned         len_eff;
		int unsigned         idx;
		logic [SAMPLE_W-1:0] d;
		logic [PROD_W-1:0]   prod;
		logic [SAMPLE_W-1:0] fb_term;
		len_eff = active_len();
		has_out = 1'b0;
		y       = '0;
		if (c == CMD_CLEAR) begin
			// zero the active part only, index stays put
			for (int i = 0; i < len_eff; i++)
				line_mem[i] = '0;
			return;
		end
		idx = line_pos;
		if (idx >= ADF_MAX_DELAY)
			idx = 0;
		d = line_mem[idx];
		// full 64-bit signed product, round, keep bits 25 up
		prod = $signed({{SAMPLE_W{d[SAMPLE_W-1]}}, d})
			* $signed({{SAMPLE_W{gain_reg[31]}}, gain_reg});
		prod = prod + ROUND_BIAS;
		fb_term = prod[GAIN_SHIFT +: SAMPLE_W];
		line_mem[idx] = x + fb_term;
		// a stale index past a lowered length wraps right here
		idx = idx + 1;
		if (idx >= len_eff || idx >= ADF_MAX_DELAY)
			idx = 0;
		line_pos = idx;
		y       = d - x;
		has_out = 1'b1;
	endfunction

	// mostly short gaps, a few long ones, and calm stretches with none
	function automatic int unsigned pick_gap(inout bit calm);
		int unsigned r;
		if ($urandom_range(0, 149) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample values: full random, small audio-like levels, and extremes
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2: begin
				return $urandom_range(0, 65535) - 32768;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	task automatic queue_req(input logic c, input logic [SAMPLE_W-1:0] x);
		adf_req_t r;
		r.cmd    = c;
		r.sample = x;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	// setup cycle, access cycle; the register takes the data at the access edge
	task automatic write_reg(input logic idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_GAIN)
			gain_reg = data;
		else
			len_reg = data[LEN_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// all requests taken and all results seen, then room for a trailing clear
	task automatic wait_idle();
		while (reqs_taken != reqs_queued || expected_outs.size() != 0)
			@(posedge clk);
		repeat (active_len() + 16) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// request driver: pulls from pending_reqs, predicts at acceptance
	// ------------------------------------------------------------------------
	adf_req_t            offered;
	int unsigned         gap_in  = 0;
	bit                  calm_in = 1'b0;
	bit                  pred_has;
	logic [SAMPLE_W-1:0] pred_out;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				allpass_step(offered.cmd, offered.sample, pred_has, pred_out);
				if (pred_has)
					expected_outs.push_back(pred_out);
				reqs_taken++;
			end
			// the slot is free unless an offer is still waiting for ready
			if (!in_valid || in_ready) begin
				if (gap_in > 0) begin
					gap_in--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					offered   = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					cmd       <= offered.cmd;
					sample_in <= offered.sample;
					gap_in    = pick_gap(calm_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: in-order compare, random stalls, two long hold-offs
	// ------------------------------------------------------------------------
	int unsigned         stall_out    = 0;
	int unsigned         hold_left    = 0;
	int unsigned         results_seen = 0;
	bit                  calm_out     = 1'b0;
	logic [SAMPLE_W-1:0] want_out;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outs.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %h",
						$time, sample_out);
					err_count++;
				end else begin
					want_out = expected_outs.pop_front();
					if (sample_out !== want_out) begin
						$display("%0t: sample_out mismatch, expected %h, got %h",
							$time, want_out, sample_out);
						err_count++;
					end
				end
				results_seen++;
				stall_out = pick_gap(calm_out);
				// long hold-off so the block backs up into its input
				if (results_seen == 150 || results_seen == 900)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_out > 0) begin
				stall_out--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: any handshake on any channel restarts the count
	// ------------------------------------------------------------------------
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_allpass_delay_filter_unit failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	logic [31:0]      gain_pick;
	logic [LEN_W-1:0] len_pick;

	initial begin
		foreach (line_mem[i])
			line_mem[i] = '0;
		line_pos = 0;
		gain_reg = '0;
		len_reg  = LEN_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// unity gain over four entries: extremes, then a second lap reads the first two back
		write_reg(REG_GAIN, 32'h0200_0000);
		write_reg(REG_LEN, 32'd4);
		queue_req(CMD_SAMPLE, 32'h7fff_ffff);
		queue_req(CMD_SAMPLE, 32'h8000_0000);
		queue_req(CMD_SAMPLE, 32'h0000_0000);
		queue_req(CMD_SAMPLE, 32'hffff_ffff);
		queue_req(CMD_SAMPLE, 32'h0000_0001);
		queue_req(CMD_SAMPLE, 32'h8000_0000);

		// largest gain, three entries, clear mid-stream
		wait_idle();
		write_reg(REG_GAIN, 32'h7fff_ffff);
		write_reg(REG_LEN, 32'd3);
		queue_req(CMD_SAMPLE, 32'h8000_0000);
		queue_req(CMD_SAMPLE, 32'h7fff_ffff);
		queue_req(CMD_SAMPLE, 32'h1234_5678);
		queue_req(CMD_SAMPLE, 32'h8000_0000);
		queue_req(CMD_CLEAR, 32'hdead_beef);
		queue_req(CMD_SAMPLE, 32'h7fff_ffff);
		queue_req(CMD_SAMPLE, 32'h0000_0005);

		// most negative gain with a zero length: wraps every sample, clear is empty
		wait_idle();
		write_reg(REG_GAIN, 32'h8000_0000);
		write_reg(REG_LEN, 32'd0);
		queue_req(CMD_SAMPLE, 32'h7fff_ffff);
		queue_req(CMD_SAMPLE, 32'h8000_0000);
		queue_req(CMD_SAMPLE, 32'h0000_0003);
		queue_req(CMD_CLEAR, 32'h0000_0000);
		queue_req(CMD_SAMPLE, 32'hffff_ffff);

		// length above the store size saturates, index moves to three
		wait_idle();
		write_reg(REG_GAIN, 32'hfe00_0000);
		write_reg(REG_LEN, 32'hffff_ffff);
		queue_req(CMD_SAMPLE, 32'h4000_0000);
		queue_req(CMD_SAMPLE, 32'hc000_0000);
		queue_req(CMD_SAMPLE, 32'h0000_7fff);

		// length dropped below the index: one sample at the stale index, then wrap
		wait_idle();
		write_reg(REG_LEN, 32'd1);
		queue_req(CMD_SAMPLE, 32'h0000_0100);
		queue_req(CMD_SAMPLE, 32'hffff_ff00);

		// random phases, each with its own gain and length
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 7))
				0: gain_pick = 32'h0000_0000;
				1: gain_pick = 32'h0200_0000;
				2: gain_pick = 32'hfe00_0000;
				3: gain_pick = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
				4, 5: gain_pick = $urandom();
				default: gain_pick = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
			endcase
			case ($urandom_range(0, 9))
				0: len_pick = 12'd0;
				1: len_pick = 12'd1;
				2: len_pick = 12'd2048;
				3: len_pick = LEN_W'($urandom_range(2049, 4095));
				4: len_pick = LEN_W'($urandom());
				default: len_pick = LEN_W'($urandom_range(2, 64));
			endcase
			if ($urandom_range(0, 1) != 0) begin
				write_reg(REG_GAIN, gain_pick);
				write_reg(REG_LEN, ($urandom() & 32'hffff_f000) | len_pick);
			end else begin
				write_reg(REG_LEN, ($urandom() & 32'hffff_f000) | len_pick);
				write_reg(REG_GAIN, gain_pick);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 63) == 0)
					queue_req(CMD_CLEAR, $urandom());
				else
					queue_req(CMD_SAMPLE, rand_sample());
			end
		end

		// drain, then a few extra cycles for anything stray
		wait_idle();
		repeat (32) @(posedge clk);
		if (expected_outs.size() != 0) begin
			$display("%0t: %0d results missing, expected %h first, got none",
				$time, expected_outs.size(), expected_outs[0]);
			err_count++;
		end
		if (err_count == 0) begin
			$display("tb_allpass_delay_filter_unit passed");
		end else begin
			$display("tb_allpass_delay_filter_unit failed");
		end
		$finish;
	end

endmodule
